[rtl/prim_mst_engine_assert.svh]
// Assertion macros used by the spanning tree engine top level.
`ifndef PRIM_MST_ENGINE_ASSERT_SVH
`define PRIM_MST_ENGINE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PME_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define PME_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/pme_pkg.sv]
// Shared types and constants of the spanning tree engine.
package pme_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int VTX_BITS         = 6;
  localparam int CNT_BITS         = 7;
  localparam int WPORT_BITS       = 16;
  localparam logic [CNT_BITS-1:0] VERTEX_COUNT_RST = 7'd64;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_INIT,
    ST_SEARCH,
    ST_DECIDE,
    ST_LOAD,
    ST_LOAD_TAIL,
    ST_RELAX,
    ST_UNREACH
  } state_t;

  typedef struct packed {
    logic                init;
    logic                shift;
    logic                relax;
    logic                mark;
    logic [VTX_BITS-1:0] pick;
    logic [CNT_BITS-1:0] count;
  } cell_ctrl_t;

endpackage

[rtl/pme_edge_mem.sv]
// Edge store: one write port, one registered read port.
module pme_edge_mem #(
  parameter int AW = 12,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/pme_cell.sv]
// One vertex cell: key, parent and flags, plus the edge and min-search shift stages.
module pme_cell import pme_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF,
  parameter int IDX          = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cell_ctrl_t                    ctrl,
  input  logic                          e_pres_i,
  input  logic [WEIGHT_BITS-1:0]        e_w_i,
  output logic                          e_pres_o,
  output logic [WEIGHT_BITS-1:0]        e_w_o,
  input  logic [WEIGHT_BITS:0]          t_key_i,
  input  logic [$clog2(MAX_VERTICES)-1:0] t_idx_i,
  input  logic [$clog2(MAX_VERTICES)-1:0] t_par_i,
  output logic [WEIGHT_BITS:0]          t_key_o,
  output logic [$clog2(MAX_VERTICES)-1:0] t_idx_o,
  output logic [$clog2(MAX_VERTICES)-1:0] t_par_o,
  output logic                          incl_o
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int KW = WEIGHT_BITS + 1;
  localparam logic [VW-1:0] MY_ID = VW'(IDX);
  localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};
  localparam logic [KW-1:0] KEY_INIT = (IDX == 0) ? '0 : KEY_INF;

  logic [KW-1:0]          key_r, key_nxt;
  logic [VW-1:0]          par_r, par_nxt;
  logic                   incl_r, incl_nxt;
  logic                   act_r, act_nxt;
  logic                   ep_r, ep_nxt;
  logic [WEIGHT_BITS-1:0] ew_r, ew_nxt;
  logic [KW-1:0]          tk_r, tk_nxt;
  logic [VW-1:0]          ti_r, ti_nxt;
  logic [VW-1:0]          tp_r, tp_nxt;
  logic                   open;
  logic                   cand;
  logic                   relax_hit;

  assign open      = act_r && !incl_r;
  assign cand      = open && (key_r < t_key_i);
  assign relax_hit = open && ep_r && ({1'b0, ew_r} < key_r);

  always_comb begin
    key_nxt  = key_r;
    par_nxt  = par_r;
    incl_nxt = incl_r;
    act_nxt  = act_r;
    if (ctrl.init) begin
      key_nxt  = KEY_INIT;
      par_nxt  = '0;
      incl_nxt = 1'b0;
      act_nxt  = CNT_BITS'(IDX) < ctrl.count;
    end else begin
      if (ctrl.relax && relax_hit) begin
        key_nxt = {1'b0, ew_r};
        par_nxt = ctrl.pick[VW-1:0];
      end
      if (ctrl.mark && (ctrl.pick[VW-1:0] == MY_ID)) begin
        incl_nxt = 1'b1;
      end
    end
    ep_nxt = ctrl.shift ? e_pres_i : ep_r;
    ew_nxt = ctrl.shift ? e_w_i : ew_r;
    // advance the running minimum; strict compare keeps the lowest index on ties
    tk_nxt = cand ? key_r : t_key_i;
    ti_nxt = cand ? MY_ID : t_idx_i;
    tp_nxt = cand ? par_r : t_par_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      incl_r <= 1'b0;
      act_r  <= 1'b0;
    end else begin
      incl_r <= incl_nxt;
      act_r  <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    par_r <= par_nxt;
    ep_r  <= ep_nxt;
    ew_r  <= ew_nxt;
    tk_r  <= tk_nxt;
    ti_r  <= ti_nxt;
    tp_r  <= tp_nxt;
  end

  assign e_pres_o = ep_r;
  assign e_w_o    = ew_r;
  assign t_key_o  = tk_r;
  assign t_idx_o  = ti_r;
  assign t_par_o  = tp_r;
  assign incl_o   = incl_r;

endmodule

[rtl/prim_mst_engine.sv]
// Prim spanning tree engine: top level with sequencer, edge store and vertex cell chain.
// Reset (synchronous, rst_n low) runs a clearing pass over the whole edge store before
// in_ready rises; a clear command runs the same pass, and an add edge reads, then writes.
// In a run, each tree step waits for the min-search word to ripple through all MAX_VERTICES
// cells, then loads one edge store row into the chain at one word per cycle. Results leave
// through a register.
`include "prim_mst_engine_assert.svh"

module prim_mst_engine import pme_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_BITS-1:0]   cfg_vertex_count,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_command,
  input  logic [VTX_BITS-1:0]   in_vertex_u,
  input  logic [VTX_BITS-1:0]   in_vertex_v,
  input  logic [WPORT_BITS-1:0] in_edge_weight,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VTX_BITS-1:0]   out_tree_vertex,
  output logic [VTX_BITS-1:0]   out_parent_vertex,
  output logic [WPORT_BITS-1:0] out_link_weight,
  output logic                  out_reachable,
  output logic                  out_last
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int AW = 2 * VW;
  localparam int KW = WEIGHT_BITS + 1;
  localparam int DW = WEIGHT_BITS + 1;
  localparam logic [CNT_BITS-1:0] N_MAX = CNT_BITS'(MAX_VERTICES);
  localparam logic [AW-1:0] SEARCH_LAST = AW'(MAX_VERTICES - 1);
  localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

  // configuration and latched command word
  logic [CNT_BITS-1:0]    vc_r;
  logic [CNT_BITS-1:0]    n_eff;
  cmd_t                   cmd_in;
  logic [VW-1:0]          u_r, v_r;
  logic [WEIGHT_BITS-1:0] w_r;
  logic                   add_ok;
  logic                   in_acc;

  // sequencer
  state_t              state_r, state_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  logic [CNT_BITS-1:0] emit_r, emit_nxt;
  logic [VW-1:0]       pick_r, pick_nxt;
  logic                sh_r;
  logic [AW-1:0]       cnt_n_last;
  logic [VW-1:0]       j_load;

  // edge store
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;
  logic [AW-1:0] add_addr, load_addr;

  // cell chain
  cell_ctrl_t             ctrl;
  logic [MAX_VERTICES:0]  ch_ep;
  logic [WEIGHT_BITS-1:0] ch_ew [MAX_VERTICES+1];
  logic [KW-1:0]          ch_tk [MAX_VERTICES+1];
  logic [VW-1:0]          ch_ti [MAX_VERTICES+1];
  logic [VW-1:0]          ch_tp [MAX_VERTICES+1];
  logic [MAX_VERTICES-1:0] incl_vec;
  logic                   found;
  logic                   u_incl;

  // result register
  logic                  out_free;
  logic                  ld_tree, ld_unr;
  logic                  ov_r;
  logic [VTX_BITS-1:0]   ot_r, op_r;
  logic [WPORT_BITS-1:0] ow_r;
  logic                  or_r, ol_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cmd_in    = cmd_t'(in_command);

  // clamp the vertex count into one..MAX_VERTICES
  assign n_eff = (vc_r == '0) ? CNT_BITS'(1) : ((vc_r > N_MAX) ? N_MAX : vc_r);
  assign cnt_n_last = AW'(n_eff - CNT_BITS'(1));
  assign j_load = VW'(n_eff - CNT_BITS'(1) - CNT_BITS'(cnt_r));

  // drop self loops and endpoints beyond storage
  assign add_ok = (in_vertex_u != in_vertex_v) &&
                  ({1'b0, in_vertex_u} < N_MAX) && ({1'b0, in_vertex_v} < N_MAX);

  // one entry per unordered pair, lower vertex in the high address half
  assign add_addr  = (u_r < v_r) ? {u_r, v_r} : {v_r, u_r};
  assign load_addr = (pick_r < j_load) ? {pick_r, j_load} : {j_load, pick_r};

  assign found    = !ch_tk[MAX_VERTICES][WEIGHT_BITS];
  assign u_incl   = incl_vec[cnt_r[VW-1:0]];
  assign out_free = !ov_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= VERTEX_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      vc_r <= cfg_vertex_count;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      u_r <= in_vertex_u[VW-1:0];
      v_r <= in_vertex_v[VW-1:0];
      w_r <= WEIGHT_BITS'(in_edge_weight);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (cnt_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (cmd_in)
            CMD_CLEAR: state_nxt = ST_CLEAR;
            CMD_ADD:   state_nxt = add_ok ? ST_ADD_RD : ST_IDLE;
            CMD_RUN:   state_nxt = ST_INIT;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD_RD:    state_nxt = ST_ADD_WR;
      ST_ADD_WR:    state_nxt = ST_IDLE;
      ST_INIT:      state_nxt = ST_SEARCH;
      ST_SEARCH: begin
        if (cnt_r == SEARCH_LAST) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!found) begin
          state_nxt = ST_UNREACH;
        end else if (out_free) begin
          state_nxt = (emit_r + CNT_BITS'(1) == n_eff) ? ST_IDLE : ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (cnt_r == cnt_n_last) state_nxt = ST_LOAD_TAIL;
      end
      ST_LOAD_TAIL: state_nxt = ST_RELAX;
      ST_RELAX:     state_nxt = ST_SEARCH;
      ST_UNREACH: begin
        if ((u_incl || out_free) && (cnt_r == cnt_n_last)) state_nxt = ST_IDLE;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs and counters
  always_comb begin
    cnt_nxt    = cnt_r;
    emit_nxt   = emit_r;
    pick_nxt   = pick_r;
    mem_we     = 1'b0;
    mem_waddr  = add_addr;
    mem_wdata  = {1'b1, w_r};
    mem_raddr  = (state_r == ST_LOAD) ? load_addr : add_addr;
    ld_tree    = 1'b0;
    ld_unr     = 1'b0;
    ctrl.init  = 1'b0;
    ctrl.shift = sh_r;
    ctrl.relax = 1'b0;
    ctrl.mark  = 1'b0;
    ctrl.pick  = VTX_BITS'(pick_r);
    ctrl.count = n_eff;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = '0;
        cnt_nxt   = cnt_r + AW'(1);
      end
      ST_IDLE: begin
        cnt_nxt  = '0;
        emit_nxt = '0;
      end
      ST_ADD_WR: begin
        // keep the smaller weight for a repeated pair
        mem_we = !mem_rdata[WEIGHT_BITS] || (w_r < mem_rdata[WEIGHT_BITS-1:0]);
      end
      ST_INIT: begin
        ctrl.init = 1'b1;
        cnt_nxt   = '0;
        emit_nxt  = '0;
      end
      ST_SEARCH: begin
        cnt_nxt = cnt_r + AW'(1);
      end
      ST_DECIDE: begin
        cnt_nxt   = '0;
        ctrl.pick = VTX_BITS'(ch_ti[MAX_VERTICES]);
        if (found && out_free) begin
          ld_tree   = 1'b1;
          ctrl.mark = 1'b1;
          pick_nxt  = ch_ti[MAX_VERTICES];
          emit_nxt  = emit_r + CNT_BITS'(1);
        end
      end
      ST_LOAD: begin
        cnt_nxt = cnt_r + AW'(1);
      end
      ST_RELAX: begin
        ctrl.relax = 1'b1;
        cnt_nxt    = '0;
      end
      ST_UNREACH: begin
        if (!u_incl && out_free) begin
          ld_unr   = 1'b1;
          emit_nxt = emit_r + CNT_BITS'(1);
        end
        if (u_incl || out_free) cnt_nxt = cnt_r + AW'(1);
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
      emit_r  <= '0;
      sh_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      emit_r  <= emit_nxt;
      // shift the row word in the cycle after its read, when the memory returns it
      sh_r    <= (state_r == ST_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    pick_r <= pick_nxt;
  end

  pme_edge_mem #(
    .AW(AW),
    .DW(DW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // chain head: row words enter at cell 0 highest vertex first; the min search
  // starts from an empty word carrying the infinite key
  assign ch_ep[0] = mem_rdata[WEIGHT_BITS];
  assign ch_ew[0] = mem_rdata[WEIGHT_BITS-1:0];
  assign ch_tk[0] = KEY_INF;
  assign ch_ti[0] = '0;
  assign ch_tp[0] = '0;

  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    pme_cell #(
      .MAX_VERTICES(MAX_VERTICES),
      .WEIGHT_BITS (WEIGHT_BITS),
      .IDX         (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .e_pres_i(ch_ep[g]),
      .e_w_i   (ch_ew[g]),
      .e_pres_o(ch_ep[g+1]),
      .e_w_o   (ch_ew[g+1]),
      .t_key_i (ch_tk[g]),
      .t_idx_i (ch_ti[g]),
      .t_par_i (ch_tp[g]),
      .t_key_o (ch_tk[g+1]),
      .t_idx_o (ch_ti[g+1]),
      .t_par_o (ch_tp[g+1]),
      .incl_o  (incl_vec[g])
    );
  end

  // result register: hold until taken, reload in the cycle it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (ld_tree || ld_unr) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_tree) begin
      ot_r <= VTX_BITS'(ch_ti[MAX_VERTICES]);
      op_r <= VTX_BITS'(ch_tp[MAX_VERTICES]);
      ow_r <= WPORT_BITS'(ch_tk[MAX_VERTICES][WEIGHT_BITS-1:0]);
      or_r <= 1'b1;
      ol_r <= (emit_r == n_eff - CNT_BITS'(1));
    end else if (ld_unr) begin
      ot_r <= VTX_BITS'(cnt_r[VW-1:0]);
      op_r <= '0;
      ow_r <= '0;
      or_r <= 1'b0;
      ol_r <= (emit_r == n_eff - CNT_BITS'(1));
    end
  end

  assign out_valid         = ov_r;
  assign out_tree_vertex   = ot_r;
  assign out_parent_vertex = op_r;
  assign out_link_weight   = ow_r;
  assign out_reachable     = or_r;
  assign out_last          = ol_r;

  `PME_ASSERT_NEXT(a_mark_adds_one, ctrl.mark, $countones(incl_vec) == $past($countones(incl_vec)) + 1)
  `PME_ASSERT_NOW(a_pick_in_range, (state_r == ST_DECIDE) && found, CNT_BITS'(ch_ti[MAX_VERTICES]) < n_eff)
  `PME_ASSERT_NOW(a_emit_bounded, (state_r != ST_IDLE) && (state_r != ST_CLEAR), emit_r <= n_eff)
  `PME_ASSERT_NOW(a_no_input_busy, (state_r != ST_IDLE), !in_ready)

endmodule

[dv/testbench.sv]
// Self-checking testbench for the Prim spanning tree engine, with its own predictor.
module testbench;
  import pme_pkg::*;

  localparam int NV        = MAX_VERTICES_DEF;
  localparam int KEY_INF   = 1 << WEIGHT_BITS_DEF;
  // The watchdog bound stays well above a test in which every item is a full run with
  // the longest output stalls.
  localparam int LIMIT     = 20_000_000;
  localparam int SETTLE    = 4200;

  typedef struct packed {
    cmd_t                  cmd;
    logic [VTX_BITS-1:0]   u;
    logic [VTX_BITS-1:0]   v;
    logic [WPORT_BITS-1:0] w;
  } edge_cmd_t;

  typedef struct packed {
    logic [VTX_BITS-1:0]   vtx;
    logic [VTX_BITS-1:0]   par;
    logic [WPORT_BITS-1:0] w;
    logic                  reach;
    logic                  last;
  } tree_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CNT_BITS-1:0]   cfg_vertex_count = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_command = CMD_NONE;
  logic [VTX_BITS-1:0]   in_vertex_u = '0;
  logic [VTX_BITS-1:0]   in_vertex_v = '0;
  logic [WPORT_BITS-1:0] in_edge_weight = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [VTX_BITS-1:0]   out_tree_vertex;
  logic [VTX_BITS-1:0]   out_parent_vertex;
  logic [WPORT_BITS-1:0] out_link_weight;
  logic                  out_reachable;
  logic                  out_last;

  prim_mst_engine i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_vertex_count  (cfg_vertex_count),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_vertex_u       (in_vertex_u),
    .in_vertex_v       (in_vertex_v),
    .in_edge_weight    (in_edge_weight),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_tree_vertex   (out_tree_vertex),
    .out_parent_vertex (out_parent_vertex),
    .out_link_weight   (out_link_weight),
    .out_reachable     (out_reachable),
    .out_last          (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: the graph as the block should hold it.
  logic [WPORT_BITS-1:0] adj_weight [NV][NV];
  bit                    adj_present [NV][NV];
  int                    vertex_count = VERTEX_COUNT_RST;

  edge_cmd_t  pending_cmds [$];
  tree_word_t tree_words [$];
  int         mismatches = 0;
  int         cycles = 0;
  bit         send_calm = 1'b0;
  bit         recv_calm = 1'b0;

  // Draw a random idle wait; calm stretches idle not at all.
  function automatic int draw_wait(ref bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic int active_vertices();
    if (vertex_count == 0) return 1;
    if (vertex_count > NV) return NV;
    return vertex_count;
  endfunction

  // Grow the tree from vertex 0 and queue one word per vertex in use.
  function automatic void grow_tree();
    int         n;
    int         pick;
    int         least;
    int         words;
    bit         joined [NV];
    int         key [NV];
    int         par [NV];
    tree_word_t tw;
    n = active_vertices();
    words = 0;
    for (int i = 0; i < NV; i++) begin
      joined[i] = 1'b0;
      key[i] = KEY_INF;
      par[i] = 0;
    end
    key[0] = 0;
    for (int i = 0; i < n; i++) begin
      pick = -1;
      least = KEY_INF;
      // strict compare: equal keys go to the lowest vertex
      for (int j = 0; j < n; j++) begin
        if (!joined[j] && key[j] < least) begin
          least = key[j];
          pick = j;
        end
      end
      if (pick < 0) break;
      joined[pick] = 1'b1;
      tw.vtx = VTX_BITS'(pick);
      tw.par = VTX_BITS'((pick == 0) ? 0 : par[pick]);
      tw.w = WPORT_BITS'((pick == 0) ? 0 : key[pick]);
      tw.reach = 1'b1;
      tw.last = 1'b0;
      tree_words = {tree_words, tw};
      words++;
      for (int j = 0; j < n; j++) begin
        if (!joined[j] && adj_present[pick][j] && adj_weight[pick][j] < key[j]) begin
          key[j] = adj_weight[pick][j];
          par[j] = pick;
        end
      end
    end
    // unreachable vertices trail in ascending order
    for (int j = 0; j < n; j++) begin
      if (!joined[j]) begin
        tw = '{vtx: VTX_BITS'(j), par: '0, w: '0, reach: 1'b0, last: 1'b0};
        tree_words = {tree_words, tw};
        words++;
      end
    end
    if (words > 0) tree_words[tree_words.size()-1].last = 1'b1;
  endfunction

  function automatic void apply_cmd(edge_cmd_t c);
    case (c.cmd)
      CMD_CLEAR: begin
        for (int a = 0; a < NV; a++)
          for (int b = 0; b < NV; b++) adj_present[a][b] = 1'b0;
      end
      CMD_ADD: begin
        if (c.u != c.v && (!adj_present[c.u][c.v] || c.w < adj_weight[c.u][c.v])) begin
          adj_weight[c.u][c.v] = c.w;
          adj_weight[c.v][c.u] = c.w;
          adj_present[c.u][c.v] = 1'b1;
          adj_present[c.v][c.u] = 1'b1;
        end
      end
      CMD_RUN: grow_tree();
      default: ;
    endcase
  endfunction

  // Driver: advance through the pending words, inserting drawn gaps.
  int send_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        apply_cmd('{cmd: cmd_t'(in_command), u: in_vertex_u, v: in_vertex_v,
                    w: in_edge_weight});
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          edge_cmd_t c;
          c = pending_cmds.pop_front();
          in_command <= c.cmd;
          in_vertex_u <= c.u;
          in_vertex_v <= c.v;
          in_edge_weight <= c.w;
          in_valid <= 1'b1;
          send_gap <= draw_wait(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each word with the oldest expectation, then maybe stall.
  int recv_stall = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      int st;
      st = recv_stall;
      if (out_valid && out_ready) begin
        tree_word_t got;
        tree_word_t want;
        got = '{vtx: out_tree_vertex, par: out_parent_vertex, w: out_link_weight,
                reach: out_reachable, last: out_last};
        if (tree_words.size() == 0) begin
          $display("%0t: unexpected word, actual %p", $time, got);
          mismatches++;
        end else begin
          want = tree_words.pop_front();
          if (got.vtx !== want.vtx)
            $display("%0t: tree_vertex expected %0d actual %0d", $time, want.vtx, got.vtx);
          if (got.par !== want.par)
            $display("%0t: parent_vertex expected %0d actual %0d", $time, want.par, got.par);
          if (got.w !== want.w)
            $display("%0t: link_weight expected %0d actual %0d", $time, want.w, got.w);
          if (got.reach !== want.reach)
            $display("%0t: reachable expected %0b actual %0b", $time, want.reach, got.reach);
          if (got.last !== want.last)
            $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
          if (got !== want) mismatches++;
        end
        st = draw_wait(recv_calm);
      end
      if (st > 0) begin
        recv_stall <= st - 1;
        out_ready <= 1'b0;
      end else begin
        recv_stall <= 0;
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void push_cmd(cmd_t cmd, int u, int v, int w);
    edge_cmd_t c;
    c = '{cmd: cmd, u: VTX_BITS'(u), v: VTX_BITS'(v), w: WPORT_BITS'(w)};
    pending_cmds = {pending_cmds, c};
  endfunction

  function automatic int rand_weight();
    // small weights often, so ties in keys show up
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
  endfunction

  // Fill one phase: mostly edges within the active range, runs, some noise.
  function automatic void fill_phase(int n, int count);
    bit cleared;
    int r;
    cleared = 1'b0;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3 && !cleared) begin
        push_cmd(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
        cleared = 1'b1;
      end else if (r < 14) begin
        push_cmd(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      end else if (r < 18) begin
        push_cmd(CMD_NONE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      end else if (r < 24) begin
        int s;
        s = $urandom_range(0, 63);
        push_cmd(CMD_ADD, s, s, rand_weight());
      end else if (r < 32) begin
        push_cmd(CMD_ADD, $urandom_range(0, 63), $urandom_range(0, 63), rand_weight());
      end else begin
        push_cmd(CMD_ADD, $urandom_range(0, n-1), $urandom_range(0, n-1), rand_weight());
      end
    end
    push_cmd(CMD_RUN, 0, 0, 0);
  endfunction

  task automatic wait_idle();
    while (pending_cmds.size() > 0 || in_valid || tree_words.size() > 0)
      @(posedge clk);
  endtask

  task automatic write_vertex_count(int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_vertex_count <= CNT_BITS'(value);
    do @(posedge clk); while (!cfg_ready);
    vertex_count = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int settings [8] = '{1, 2, 5, 12, 64, 0, 127, 8};
    int n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty graph, extreme weights, self loop, repeated pairs, ties, clear.
    push_cmd(CMD_RUN, 0, 0, 0);
    push_cmd(CMD_ADD, 0, 1, 16'h0000);
    push_cmd(CMD_ADD, 1, 2, 16'hFFFF);
    push_cmd(CMD_ADD, 3, 3, 1);
    push_cmd(CMD_ADD, 1, 0, 9);
    push_cmd(CMD_ADD, 2, 1, 5);
    push_cmd(CMD_ADD, 63, 62, 16'hFFFF);
    push_cmd(CMD_ADD, 0, 3, 7);
    push_cmd(CMD_ADD, 0, 4, 7);
    push_cmd(CMD_ADD, 62, 0, 16'hAAAA);
    push_cmd(CMD_NONE, 63, 63, 16'hFFFF);
    push_cmd(CMD_RUN, 63, 63, 16'hFFFF);
    push_cmd(CMD_CLEAR, 63, 63, 16'hFFFF);
    push_cmd(CMD_RUN, 0, 0, 0);
    push_cmd(CMD_ADD, 0, 63, 1);
    push_cmd(CMD_ADD, 63, 5, 16'h5555);
    push_cmd(CMD_RUN, 0, 0, 0);
    wait_idle();
    repeat (SETTLE) @(posedge clk);

    foreach (settings[i]) begin
      write_vertex_count(settings[i]);
      n = active_vertices();
      fill_phase(n, 48);
      wait_idle();
      repeat (SETTLE) @(posedge clk);
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0 && tree_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/pme_pkg.sv
rtl/pme_edge_mem.sv
rtl/pme_cell.sv
rtl/prim_mst_engine.sv
dv/testbench.sv
